### rtl/ymbr_pkg.sv
// Package: shared types, codes and the CRC-16 byte update for the YMODEM block receiver.
package ymbr_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;

  // Reply codes.
  localparam logic [1:0] RPL_NONE = 2'd0;
  localparam logic [1:0] RPL_ACK  = 2'd1;
  localparam logic [1:0] RPL_NAK  = 2'd2;
  localparam logic [1:0] RPL_C    = 2'd3;

  // Block verdict codes.
  localparam logic [3:0] ST_NONE     = 4'd0;
  localparam logic [3:0] ST_NEW      = 4'd1;
  localparam logic [3:0] ST_DUP      = 4'd2;
  localparam logic [3:0] ST_WRONG    = 4'd3;
  localparam logic [3:0] ST_BADCMP   = 4'd4;
  localparam logic [3:0] ST_BADCRC   = 4'd5;
  localparam logic [3:0] ST_GARBAGE  = 4'd6;
  localparam logic [3:0] ST_EOT      = 4'd7;
  localparam logic [3:0] ST_CANCEL   = 4'd8;
  localparam logic [3:0] ST_TIMEOUT  = 4'd9;
  localparam logic [3:0] ST_SESS_END = 4'd10;

  // Line control characters.
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [10:0] SHORT_LEN = 11'd128;
  localparam logic [10:0] LONG_LEN  = 11'd1024;

  // One result word.
  typedef struct packed {
    logic [1:0] reply;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [3:0] block_status;
    logic       is_header;
    logic [7:0] block_number;
    logic       long_block;
    logic       last;
  } result_t;

  // Results caused by one input word.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_out_t;

  // Output queue status seen by the top level.
  typedef struct packed {
    logic       room;
    logic [2:0] fill;
  } queue_status_t;

  // CRC-16-CCITT, MSB first, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/ymbr_ifs.sv
// Interfaces: input word channel and result word channel.
interface ymbr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface ymbr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [3:0] block_status;
  logic       is_header;
  logic [7:0] block_number;
  logic       long_block;
  logic       last;

  modport source (output valid, output reply, output data_valid, output data_byte,
                  output block_status, output is_header, output block_number,
                  output long_block, output last, input ready);
  modport sink   (input valid, input reply, input data_valid, input data_byte,
                  input block_status, input is_header, input block_number,
                  input long_block, input last, output ready);
endinterface

### rtl/ymbr_fsm.sv
// Protocol state machine: deframing, sequence and CRC checks, verdict results.
module ymbr_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [1:0]           operation,
  input  logic [7:0]           rx_byte,
  output ymbr_pkg::step_out_t  results
);
  import ymbr_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_LEAD    = 4'd1;
  localparam logic [3:0] PH_SEQ     = 4'd2;
  localparam logic [3:0] PH_NSEQ    = 4'd3;
  localparam logic [3:0] PH_DATA    = 4'd4;
  localparam logic [3:0] PH_CRCH    = 4'd5;
  localparam logic [3:0] PH_CRCL    = 4'd6;
  localparam logic [3:0] PH_DISCARD = 4'd7;
  localparam logic [3:0] PH_EOTWAIT = 4'd8;

  logic [3:0]  phase, phase_next;
  logic        header_expected, header_expected_next;
  logic        long_payload, long_payload_next;
  logic [10:0] byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_high, received_crc_high_next;
  logic [7:0]  block_seq, block_seq_next;
  logic [7:0]  expected_seq, expected_seq_next;
  logic        first_byte_zero, first_byte_zero_next;
  logic [3:0]  pending_error, pending_error_next;

  logic        go_lead;
  logic [3:0]  lead_phase;
  logic [1:0]  n;
  result_t     r0, r1;
  logic [15:0] crc_upd;
  logic [10:0] count_inc;
  logic [1:0]  retry;

  assign crc_upd   = crc_byte(running_crc, rx_byte);
  assign count_inc = byte_count + 11'd1;
  assign retry     = header_expected ? RPL_C : RPL_NAK;

  // Next state and results for the word in the input register.
  always_comb begin
    phase_next             = phase;
    header_expected_next   = header_expected;
    long_payload_next      = long_payload;
    byte_count_next        = byte_count;
    running_crc_next       = running_crc;
    received_crc_high_next = received_crc_high;
    block_seq_next         = block_seq;
    expected_seq_next      = expected_seq;
    first_byte_zero_next   = first_byte_zero;
    pending_error_next     = pending_error;
    go_lead    = 1'b0;
    lead_phase = PH_LEAD;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    case (operation)
      OP_START: begin
        header_expected_next = 1'b1;
        expected_seq_next    = 8'd1;
        go_lead  = 1'b1;
        n        = 2'd1;
        r0.reply = RPL_C;
      end
      OP_TIMEOUT: begin
        if (phase == PH_EOTWAIT) begin
          n = 2'd2;
          r0.reply        = RPL_ACK;
          r0.block_status = ST_TIMEOUT;
          r1.reply        = RPL_C;
          header_expected_next = 1'b1;
          go_lead = 1'b1;
        end else if (phase != PH_IDLE) begin
          n = 2'd1;
          r0.reply        = retry;
          r0.block_status = (phase == PH_DISCARD) ? pending_error : ST_TIMEOUT;
          r0.is_header    = header_expected;
          r0.block_number = block_seq;
          r0.long_block   = long_payload;
          go_lead = 1'b1;
        end
      end
      OP_BYTE: begin
        case (phase)
          PH_LEAD: begin
            if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
              long_payload_next = (rx_byte == CH_STX);
              byte_count_next   = '0;
              running_crc_next  = '0;
              phase_next        = PH_SEQ;
            end else if (rx_byte == CH_EOT) begin
              if (header_expected) begin
                n = 2'd2;
                r0.reply        = RPL_ACK;
                r0.block_status = ST_EOT;
                r0.is_header    = 1'b1;
                r1.reply        = RPL_C;
              end else begin
                n = 2'd1;
                r0.reply        = RPL_NAK;
                r0.block_status = ST_EOT;
                phase_next      = PH_EOTWAIT;
              end
            end else if (rx_byte == CH_CAN) begin
              n = 2'd1;
              r0.block_status = ST_CANCEL;
              r0.is_header    = header_expected;
              phase_next      = PH_IDLE;
            end else begin
              pending_error_next = ST_GARBAGE;
              phase_next         = PH_DISCARD;
            end
          end
          PH_SEQ: begin
            block_seq_next = rx_byte;
            phase_next     = PH_NSEQ;
          end
          PH_NSEQ: begin
            if ((block_seq ^ rx_byte) != 8'hFF) begin
              pending_error_next = ST_BADCMP;
              phase_next         = PH_DISCARD;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            if (byte_count == '0) begin
              first_byte_zero_next = (rx_byte == 8'h00);
            end
            running_crc_next = crc_upd;
            byte_count_next  = count_inc;
            n = 2'd1;
            r0.data_valid   = 1'b1;
            r0.data_byte    = rx_byte;
            r0.is_header    = header_expected;
            r0.block_number = block_seq;
            r0.long_block   = long_payload;
            if (count_inc >= (long_payload ? LONG_LEN : SHORT_LEN)) begin
              phase_next = PH_CRCH;
            end
          end
          PH_CRCH: begin
            received_crc_high_next = rx_byte;
            phase_next             = PH_CRCL;
          end
          PH_CRCL: begin
            r0.reply        = RPL_ACK;
            r0.block_number = block_seq;
            r0.long_block   = long_payload;
            if ({received_crc_high, rx_byte} != running_crc) begin
              r0 = '0;
              pending_error_next = ST_BADCRC;
              phase_next         = PH_DISCARD;
            end else if (header_expected) begin
              r0.is_header = 1'b1;
              go_lead      = 1'b1;
              if (first_byte_zero) begin
                n = 2'd1;
                r0.block_status = ST_SESS_END;
                lead_phase      = PH_IDLE;
              end else begin
                n = 2'd2;
                r0.block_status = ST_NEW;
                r1.reply        = RPL_C;
                header_expected_next = 1'b0;
                expected_seq_next    = 8'd1;
              end
            end else if (block_seq == expected_seq) begin
              n = 2'd1;
              r0.block_status   = ST_NEW;
              expected_seq_next = expected_seq + 8'd1;
              go_lead           = 1'b1;
            end else if (block_seq == expected_seq - 8'd1) begin
              n = 2'd1;
              r0.block_status = ST_DUP;
              go_lead         = 1'b1;
            end else begin
              r0 = '0;
              pending_error_next = ST_WRONG;
              phase_next         = PH_DISCARD;
            end
          end
          PH_EOTWAIT: begin
            n = 2'd2;
            r0.reply        = RPL_ACK;
            r0.block_status = (rx_byte == CH_EOT) ? ST_EOT : ST_GARBAGE;
            r1.reply        = RPL_C;
            header_expected_next = 1'b1;
            go_lead = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    // Return to waiting for a lead byte with the block context cleared.
    if (go_lead) begin
      phase_next             = lead_phase;
      long_payload_next      = 1'b0;
      byte_count_next        = '0;
      running_crc_next       = '0;
      received_crc_high_next = '0;
      block_seq_next         = '0;
      first_byte_zero_next   = 1'b0;
      pending_error_next     = '0;
    end
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign results.count = step ? n : 2'd0;
  assign results.r0    = r0;
  assign results.r1    = r1;

  // State registers, updated once per processed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      header_expected   <= 1'b1;
      long_payload      <= 1'b0;
      byte_count        <= '0;
      running_crc       <= '0;
      received_crc_high <= '0;
      block_seq         <= '0;
      expected_seq      <= 8'd1;
      first_byte_zero   <= 1'b0;
      pending_error     <= '0;
    end else if (step) begin
      phase             <= phase_next;
      header_expected   <= header_expected_next;
      long_payload      <= long_payload_next;
      byte_count        <= byte_count_next;
      running_crc       <= running_crc_next;
      received_crc_high <= received_crc_high_next;
      block_seq         <= block_seq_next;
      expected_seq      <= expected_seq_next;
      first_byte_zero   <= first_byte_zero_next;
      pending_error     <= pending_error_next;
    end
  end

endmodule

### rtl/ymbr_outq.sv
// Four-entry result queue that takes up to two result words per cycle.
module ymbr_outq (
  input  logic                     clk,
  input  logic                     rst,
  input  ymbr_pkg::step_out_t      push,
  output ymbr_pkg::queue_status_t  status,
  ymbr_out_if.source               egress
);
  import ymbr_pkg::*;

  result_t    entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  logic       pop;
  result_t    head;

  assign pop  = egress.valid && egress.ready;
  assign head = entries[rd_ptr];

  // Queue storage writes.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.r1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      fill   <= fill + {1'b0, push.count} - {2'b00, pop};
    end
  end

  assign status.fill = fill;
  assign status.room = (fill <= 3'd2);

  assign egress.valid        = (fill != 3'd0);
  assign egress.reply        = head.reply;
  assign egress.data_valid   = head.data_valid;
  assign egress.data_byte    = head.data_byte;
  assign egress.block_status = head.block_status;
  assign egress.is_header    = head.is_header;
  assign egress.block_number = head.block_number;
  assign egress.long_block   = head.long_block;
  assign egress.last         = head.last;

endmodule

### rtl/ymbr_outq_dummy_guard.sv
// Input word register that feeds the state machine one word per cycle while step is high.
module ymbr_inreg (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  output logic        held,
  output logic [1:0]  operation,
  output logic [7:0]  rx_byte,
  ymbr_in_if.sink     ingress
);
  import ymbr_pkg::*;

  logic accept;

  assign ingress.ready = !held || step;
  assign accept        = ingress.valid && ingress.ready;

  // Valid flag of the held word.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (ingress.ready) begin
      held <= ingress.valid;
    end
  end

  // Payload of the held word.
  always_ff @(posedge clk) begin
    if (accept) begin
      operation <= ingress.operation;
      rx_byte   <= ingress.rx_byte;
    end
  end

endmodule

### rtl/ymodem_block_receiver_core.sv
// YMODEM block receiver core: input register, state machine and result queue.
// A result word is offered by the result queue after the state machine has processed
// its input word, which waits in the input register while the queue lacks room.
// Throughput: one input word per cycle while the queue has room for two results; the
// results of a word leave one at a time through the single-word output channel.
// Reset (synchronous, active high) returns to idle with a header expected and
// empties the input register and the result queue.
module ymodem_block_receiver_core (
  input  logic        clk,
  input  logic        rst,
  ymbr_in_if.sink     ingress,
  ymbr_out_if.source  egress
);
  import ymbr_pkg::*;

  logic          held;
  logic          step;
  logic [1:0]    op_q;
  logic [7:0]    byte_q;
  step_out_t     results;
  queue_status_t q_status;

  // A held word is processed once the queue can take two results.
  assign step = held && q_status.room;

  ymbr_inreg u_inreg (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .held      (held),
    .operation (op_q),
    .rx_byte   (byte_q),
    .ingress   (ingress)
  );

  ymbr_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .operation (op_q),
    .rx_byte   (byte_q),
    .results   (results)
  );

  ymbr_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (results),
    .status (q_status),
    .egress (egress)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.fill <= 3'd4)
    else $error("result queue overfilled");

  a_no_accept_when_stuck: assert property (@(posedge clk) disable iff (rst)
    (held && !step) |-> !ingress.ready)
    else $error("input accepted while held word is stalled");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (results.count != 2'd0) |=> egress.valid)
    else $error("pushed result word not offered");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !egress.valid)
    else $error("result offered right after reset");
`endif

endmodule

### dv/tb.sv
// Testbench for the YMODEM block receiver core: line-protocol predictor, scoreboard and traffic.
`timescale 1ns / 100ps

import ymbr_pkg::*;

// Operation code that the block ignores.
localparam logic [1:0] OP_SPARE = 2'd3;

// Receiver phases as tracked by the predictor.
typedef enum logic [3:0] {
  RX_IDLE, RX_LEAD, RX_SEQ, RX_NSEQ, RX_DATA, RX_CRC_HI, RX_CRC_LO, RX_DISCARD, RX_EOT_WAIT
} rx_phase_t;

// Scoreboard: follows the receiver protocol word by word and checks every result word.
class ymodem_scoreboard;
  rx_phase_t   phase;
  logic        hdr_expected;
  logic        long_pl;
  logic [10:0] count;
  logic [15:0] crc;
  logic [7:0]  crc_hi;
  logic [7:0]  blk_seq;
  logic [7:0]  next_seq;
  logic        first_zero;
  logic [3:0]  held_verdict;
  result_t     results_due[$];
  int          errors;
  int          results_seen;

  function new();
    phase        = RX_IDLE;
    hdr_expected = 1'b1;
    next_seq     = 8'd1;
    errors       = 0;
    results_seen = 0;
    enter_lead();
    phase        = RX_IDLE;
  endfunction

  // CRC-16-CCITT, fed one bit at a time, MSB first.
  static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function void enter_lead();
    phase        = RX_LEAD;
    long_pl      = 1'b0;
    count        = '0;
    crc          = '0;
    crc_hi       = '0;
    blk_seq      = '0;
    first_zero   = 1'b0;
    held_verdict = ST_NONE;
  endfunction

  function logic [1:0] retry_code();
    return hdr_expected ? RPL_C : RPL_NAK;
  endfunction

  function int outstanding();
    return results_due.size();
  endfunction

  function void queue_result(logic [1:0] reply, logic dv, logic [7:0] db, logic [3:0] st,
                             logic hdr, logic [7:0] bn, logic lg);
    result_t r;
    r.reply        = reply;
    r.data_valid   = dv;
    r.data_byte    = db;
    r.block_status = st;
    r.is_header    = hdr;
    r.block_number = bn;
    r.long_block   = lg;
    r.last         = 1'b0;
    results_due.push_back(r);
  endfunction

  // Note one accepted input word and queue the result words it causes.
  function void take_rx_word(logic [1:0] op, logic [7:0] b);
    int      base;
    result_t tail;
    base = results_due.size();
    case (op)
      OP_START: begin
        hdr_expected = 1'b1;
        next_seq     = 8'd1;
        enter_lead();
        queue_result(RPL_C, 1'b0, 8'h00, ST_NONE, 1'b0, 8'h00, 1'b0);
      end
      OP_TIMEOUT: begin
        if (phase == RX_EOT_WAIT) begin
          queue_result(RPL_ACK, 1'b0, 8'h00, ST_TIMEOUT, 1'b0, 8'h00, 1'b0);
          queue_result(RPL_C, 1'b0, 8'h00, ST_NONE, 1'b0, 8'h00, 1'b0);
          hdr_expected = 1'b1;
          enter_lead();
        end else if (phase == RX_DISCARD) begin
          queue_result(retry_code(), 1'b0, 8'h00, held_verdict, hdr_expected, blk_seq, long_pl);
          enter_lead();
        end else if (phase != RX_IDLE) begin
          queue_result(retry_code(), 1'b0, 8'h00, ST_TIMEOUT, hdr_expected, blk_seq, long_pl);
          enter_lead();
        end
      end
      OP_BYTE: begin
        case (phase)
          RX_LEAD: begin
            if (b == CH_SOH || b == CH_STX) begin
              long_pl = (b == CH_STX);
              count   = '0;
              crc     = '0;
              phase   = RX_SEQ;
            end else if (b == CH_EOT) begin
              if (hdr_expected) begin
                queue_result(RPL_ACK, 1'b0, 8'h00, ST_EOT, 1'b1, 8'h00, 1'b0);
                queue_result(RPL_C, 1'b0, 8'h00, ST_NONE, 1'b0, 8'h00, 1'b0);
              end else begin
                queue_result(RPL_NAK, 1'b0, 8'h00, ST_EOT, 1'b0, 8'h00, 1'b0);
                phase = RX_EOT_WAIT;
              end
            end else if (b == CH_CAN) begin
              queue_result(RPL_NONE, 1'b0, 8'h00, ST_CANCEL, hdr_expected, 8'h00, 1'b0);
              phase = RX_IDLE;
            end else begin
              held_verdict = ST_GARBAGE;
              phase        = RX_DISCARD;
            end
          end
          RX_SEQ: begin
            blk_seq = b;
            phase   = RX_NSEQ;
          end
          RX_NSEQ: begin
            if ((blk_seq ^ b) != 8'hFF) begin
              held_verdict = ST_BADCMP;
              phase        = RX_DISCARD;
            end else begin
              phase = RX_DATA;
            end
          end
          RX_DATA: begin
            if (count == 0) first_zero = (b == 8'h00);
            crc   = crc_next(crc, b);
            count = count + 11'd1;
            queue_result(RPL_NONE, 1'b1, b, ST_NONE, hdr_expected, blk_seq, long_pl);
            if (count >= (long_pl ? LONG_LEN : SHORT_LEN)) phase = RX_CRC_HI;
          end
          RX_CRC_HI: begin
            crc_hi = b;
            phase  = RX_CRC_LO;
          end
          RX_CRC_LO: begin
            if ({crc_hi, b} != crc) begin
              held_verdict = ST_BADCRC;
              phase        = RX_DISCARD;
            end else if (hdr_expected) begin
              if (first_zero) begin
                // An empty header closes the session.
                queue_result(RPL_ACK, 1'b0, 8'h00, ST_SESS_END, 1'b1, blk_seq, long_pl);
                enter_lead();
                phase = RX_IDLE;
              end else begin
                queue_result(RPL_ACK, 1'b0, 8'h00, ST_NEW, 1'b1, blk_seq, long_pl);
                queue_result(RPL_C, 1'b0, 8'h00, ST_NONE, 1'b0, 8'h00, 1'b0);
                hdr_expected = 1'b0;
                next_seq     = 8'd1;
                enter_lead();
              end
            end else if (blk_seq == next_seq) begin
              queue_result(RPL_ACK, 1'b0, 8'h00, ST_NEW, 1'b0, blk_seq, long_pl);
              next_seq = next_seq + 8'd1;
              enter_lead();
            end else if (blk_seq == next_seq - 8'd1) begin
              queue_result(RPL_ACK, 1'b0, 8'h00, ST_DUP, 1'b0, blk_seq, long_pl);
              enter_lead();
            end else begin
              held_verdict = ST_WRONG;
              phase        = RX_DISCARD;
            end
          end
          RX_EOT_WAIT: begin
            // The word after the first EOT of a file closes it.
            queue_result(RPL_ACK, 1'b0, 8'h00, (b == CH_EOT) ? ST_EOT : ST_GARBAGE,
                         1'b0, 8'h00, 1'b0);
            queue_result(RPL_C, 1'b0, 8'h00, ST_NONE, 1'b0, 8'h00, 1'b0);
            hdr_expected = 1'b1;
            enter_lead();
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // Mark the final result word of this input word.
    if (results_due.size() > base) begin
      tail      = results_due.pop_back();
      tail.last = 1'b1;
      results_due.push_back(tail);
    end
  endfunction

  task report(string msg);
    if (errors < 100) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Compare one accepted result word with the oldest expected one.
  task check_result(result_t got);
    result_t want;
    string   bad;
    results_seen++;
    if (results_due.size() == 0) begin
      report($sformatf("result %0d arrived with none expected: %h", results_seen, got));
      return;
    end
    want = results_due.pop_front();
    bad  = "";
    if (got.reply !== want.reply) bad = {bad, " reply"};
    if (got.data_valid !== want.data_valid) bad = {bad, " data_valid"};
    if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
    if (got.block_status !== want.block_status) bad = {bad, " block_status"};
    if (got.is_header !== want.is_header) bad = {bad, " is_header"};
    if (got.block_number !== want.block_number) bad = {bad, " block_number"};
    if (got.long_block !== want.long_block) bad = {bad, " long_block"};
    if (got.last !== want.last) bad = {bad, " last"};
    if (bad.len() != 0)
      report($sformatf("result %0d wrong in%s: got %h, expected %h",
                       results_seen, bad, got, want));
  endtask
endclass

module tb;
  localparam int ITEM_TARGET    = 700;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;

  logic clk;
  logic rst;
  bit   rx_hold;
  int   src_left;
  bit   src_quiet;
  int   quiet_cycles;
  int   items_sent;

  ymodem_scoreboard sb;

  ymbr_in_if  in_ch ();
  ymbr_out_if out_ch ();

  ymodem_block_receiver_core DUT (
    .clk     (clk),
    .rst     (rst),
    .ingress (in_ch),
    .egress  (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wait drawn per word, with occasional stretches that run without gaps.
  function automatic int draw_gap(inout int left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(16, 128);
      quiet = ($urandom_range(0, 3) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  // Offer one input word and hold it until the block takes it.
  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    int gap;
    gap = draw_gap(src_left, src_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.rx_byte   <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_rx_word(op, b);
    items_sent++;
  endtask

  // Stop offering and wait until every expected result word has been taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Send one block frame; cut >= 0 stops after that many bytes.
  task automatic send_frame(input bit long_blk, input logic [7:0] seq, input logic [7:0] first_b,
                            input bit bad_cmp, input bit bad_crc, input int cut);
    logic [7:0]  frame[$];
    logic [7:0]  b;
    logic [7:0]  nseq;
    logic [15:0] c;
    int          len;
    int          stop;
    len  = long_blk ? 1024 : 128;
    nseq = ~seq;
    if (bad_cmp) nseq = nseq ^ 8'($urandom_range(1, 255));
    frame.push_back(long_blk ? CH_STX : CH_SOH);
    frame.push_back(seq);
    frame.push_back(nseq);
    c = 16'h0000;
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? first_b : 8'($urandom_range(0, 255));
      c = crc_byte(c, b);
      frame.push_back(b);
    end
    if (bad_crc) c = c ^ 16'($urandom_range(1, 65535));
    frame.push_back(c[15:8]);
    frame.push_back(c[7:0]);
    stop = (cut >= 0 && cut < frame.size()) ? cut : frame.size();
    for (int i = 0; i < stop; i++) send_word(OP_BYTE, frame[i]);
  endtask

  // Directed opening: idle words, most verdicts, EOT closing, cancel, restart and session end.
  task automatic run_directed();
    send_word(OP_SPARE, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_TIMEOUT, 8'h00);
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, CH_EOT);
    send_word(OP_TIMEOUT, 8'hFF);
    // Garbage lead, then discarded bytes until the quiet timeout.
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, CH_SOH);
    send_word(OP_TIMEOUT, 8'h00);
    send_frame(1'b0, 8'hFF, 8'hFF, 1'b0, 1'b0, -1);
    // Long block cut short and closed by a timeout.
    send_frame(1'b1, 8'h01, 8'h00, 1'b0, 1'b0, 14);
    send_word(OP_TIMEOUT, 8'h00);
    // First data block while the receiver holds off, then a full drain.
    rx_hold = 1'b1;
    send_frame(1'b0, 8'h01, 8'hFF, 1'b0, 1'b0, -1);
    wait_drained();
    send_frame(1'b0, 8'h02, 8'h00, 1'b1, 1'b0, 3);
    send_word(OP_TIMEOUT, 8'h00);
    send_frame(1'b0, 8'h02, 8'h00, 1'b0, 1'b1, -1);
    send_word(OP_TIMEOUT, 8'h00);
    send_frame(1'b0, 8'h02, 8'h00, 1'b0, 1'b0, 6);
    send_word(OP_TIMEOUT, 8'h00);
    send_word(OP_BYTE, CH_EOT);
    send_word(OP_BYTE, CH_EOT);
    // Restart in the middle of a frame, then cancel.
    send_frame(1'b0, 8'h05, 8'h11, 1'b0, 1'b0, 10);
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, CH_CAN);
    send_word(OP_START, 8'h00);
    send_frame(1'b0, 8'h00, 8'h00, 1'b0, 1'b0, -1);
  endtask

  // One random step: well-formed frames most often, with broken frames and noise.
  task automatic random_step();
    int         pick;
    int         r;
    int         extra;
    logic [7:0] seq;
    logic [7:0] b;
    bit         lng;
    lng = ($urandom_range(0, 3) == 0);
    if (sb.phase == RX_IDLE) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_word(OP_BYTE, 8'($urandom_range(0, 255)));
          1:       send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
          default: send_word(OP_SPARE, 8'($urandom_range(0, 255)));
        endcase
      end else begin
        send_word(OP_START, 8'($urandom_range(0, 255)));
      end
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if (sb.hdr_expected) begin
        seq = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
        b   = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        send_frame(1'b0, seq, b, 1'b0, 1'b0, -1);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 7) seq = sb.next_seq;
        else if (r < 9) seq = sb.next_seq - 8'd1;
        else seq = sb.next_seq + 8'($urandom_range(1, 254));
        send_frame(1'b0, seq, 8'($urandom_range(0, 255)), 1'b0, 1'b0, -1);
        if (sb.phase == RX_DISCARD) send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
      end
    end else if (pick < 55) begin
      send_frame(lng, sb.next_seq, 8'($urandom_range(0, 255)), 1'b1, 1'b0,
                 $urandom_range(3, 12));
      send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
    end else if (pick < 65) begin
      send_frame(1'b0, sb.next_seq, 8'($urandom_range(1, 255)), 1'b0, 1'b1, -1);
      send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
    end else if (pick < 73) begin
      send_frame(lng, sb.next_seq, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                 $urandom_range(1, 40));
      send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
    end else if (pick < 81) begin
      send_word(OP_BYTE, CH_EOT);
      if (sb.phase == RX_EOT_WAIT) begin
        r = $urandom_range(0, 19);
        if (r < 12) begin
          send_word(OP_BYTE, CH_EOT);
        end else if (r < 16) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_EOT);
          send_word(OP_BYTE, b);
        end else begin
          send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        end
      end
    end else if (pick < 85) begin
      do b = 8'($urandom_range(0, 255));
      while (b == CH_SOH || b == CH_STX || b == CH_EOT || b == CH_CAN);
      send_word(OP_BYTE, b);
      extra = $urandom_range(0, 3);
      repeat (extra) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
      send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      send_word(OP_BYTE, CH_CAN);
    end else if (pick < 91) begin
      send_word(OP_START, 8'($urandom_range(0, 255)));
    end else if (pick < 94) begin
      send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      send_word(OP_SPARE, 8'($urandom_range(0, 255)));
    end else begin
      extra = $urandom_range(1, 6);
      repeat (extra) send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      send_word(OP_TIMEOUT, 8'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    sb              = new();
    rx_hold         = 1'b0;
    src_left        = 0;
    src_quiet       = 1'b0;
    items_sent      = 0;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_BYTE;
    in_ch.rx_byte   <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    while (items_sent < ITEM_TARGET) random_step();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.outstanding()));
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random ready gaps, one long hold-off on request.
  initial begin : result_sink
    int      gap;
    int      left;
    bit      quiet;
    result_t got;
    left         = 0;
    quiet        = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      gap = draw_gap(left, quiet);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.reply        = out_ch.reply;
      got.data_valid   = out_ch.data_valid;
      got.data_byte    = out_ch.data_byte;
      got.block_status = out_ch.block_status;
      got.is_header    = out_ch.is_header;
      got.block_number = out_ch.block_number;
      got.long_block   = out_ch.long_block;
      got.last         = out_ch.last;
      sb.check_result(got);
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end
endmodule
